// ===== rtl/core/fcgi_pkg.sv =====
// Package for the FastCGI record deframer: record type codes, stream kinds,
// the parse phase type and the result word layout.
// No dependencies.
package fcgi_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned REQ_W   = 16;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned PAD_W   = 8;
    localparam int unsigned HIDX_W  = 3;

    // record types carried in header byte 1
    localparam logic [BYTE_W-1:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [BYTE_W-1:0] TYPE_STDOUT      = 8'd6;
    localparam logic [BYTE_W-1:0] TYPE_STDERR      = 8'd7;

    // header byte positions
    localparam logic [HIDX_W-1:0] HDR_TYPE    = 3'd1;
    localparam logic [HIDX_W-1:0] HDR_REQ_HI  = 3'd2;
    localparam logic [HIDX_W-1:0] HDR_REQ_LO  = 3'd3;
    localparam logic [HIDX_W-1:0] HDR_LEN_HI  = 3'd4;
    localparam logic [HIDX_W-1:0] HDR_LEN_LO  = 3'd5;
    localparam logic [HIDX_W-1:0] HDR_PAD     = 3'd6;
    localparam logic [HIDX_W-1:0] HDR_LAST    = 3'd7;

    // stream kind tags on the result
    localparam logic [KIND_W-1:0] KIND_STDOUT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STDERR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_REQ = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [KIND_W-1:0] stream_kind;
        logic [REQ_W-1:0]  request_id;
        logic              record_last;
    } t_result;

endpackage

// ===== rtl/core/fcgi_if.sv =====
// Valid/ready channel interfaces for the FastCGI record deframer:
// the raw byte input channel and the tagged content output channel.
// No dependencies.
interface fcgi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface fcgi_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [1:0]  stream_kind;
    logic [15:0] request_id;
    logic        record_last;

    modport source (output valid, output data_byte, output stream_kind,
                    output request_id, output record_last, input ready);
    modport sink   (input valid, input data_byte, input stream_kind,
                    input request_id, input record_last, output ready);
endinterface

// ===== rtl/core/fcgi_skid.sv =====
// Output register with one skid entry for the deframer result words.
// Depends on fcgi_pkg (t_result).
module fcgi_skid
    import fcgi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out_data, n_out_data;
    t_result r_skid_data, n_skid_data;
    logic    accept;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_ready) begin
            // output slot frees up: drain skid first, else take the new word
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out_data  = i_data;
            end
        end else if (accept) begin
            // output stalled: park the word
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid entry filled without an output stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output register");

endmodule

// ===== rtl/core/fastcgi_record_deframer.sv =====
// FastCGI record deframer, top level: header parse, content tagging and
// the output register stage. Depends on fcgi_pkg, fcgi_if.sv, fcgi_skid.
//
// Feed the FastCGI response stream one byte per word on i_in. Each record
// is an 8-byte header (version, type, request id hi/lo, content length
// hi/lo, padding length, reserved), then its content, then its padding.
// Every content byte of a STDOUT, STDERR or END_REQUEST record comes out on
// o_out as one word, tagged with the stream kind (0 stdout, 1 stderr,
// 2 end-request body) and the header's request id; record_last is set on
// the record's final content byte. Header bytes, padding bytes and the
// content of any other record type produce nothing and are skipped by the
// header's lengths. The version and reserved bytes are not checked. Rate:
// one byte per clock while i_in.ready is high; each result is registered
// in the output register, or parked in the skid entry while o_out stalls.
// The parse state updates on each accepted byte; the output register and
// one skid entry keep i_in.ready high until o_out stalls with both full.
module fastcgi_record_deframer
    import fcgi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fcgi_in_if.sink    i_in,
    fcgi_out_if.source o_out
);

    // parse state
    t_phase             r_phase, n_phase;
    logic [HIDX_W-1:0]  r_hidx, n_hidx;
    logic [BYTE_W-1:0]  r_rec_type, n_rec_type;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [LEN_W-1:0]   r_content_left, n_content_left;
    logic [PAD_W-1:0]   r_pad_left, n_pad_left;

    logic               in_accept;
    logic               buf_ready;
    logic               res_valid;
    logic               kind_ok;
    logic [KIND_W-1:0]  kind;
    logic               last_byte;
    t_result            res_data;
    t_result            out_data;

    assign i_in.ready = buf_ready;
    assign in_accept  = i_in.valid && buf_ready;
    assign last_byte  = (r_content_left <= LEN_W'(1));

    // Map the record type to a stream kind; other types pass silently.
    always_comb begin
        kind_ok = 1'b1;
        case (r_rec_type)
            TYPE_STDOUT:      kind = KIND_STDOUT;
            TYPE_STDERR:      kind = KIND_STDERR;
            TYPE_END_REQUEST: kind = KIND_END_REQ;
            default: begin
                kind    = KIND_STDOUT;
                kind_ok = 1'b0;
            end
        endcase
    end

    // Next state: advance only on an accepted byte.
    always_comb begin
        n_phase        = r_phase;
        n_hidx         = r_hidx;
        n_rec_type     = r_rec_type;
        n_req          = r_req;
        n_content_left = r_content_left;
        n_pad_left     = r_pad_left;
        if (in_accept) begin
            case (r_phase)
                PH_CONTENT: begin
                    n_content_left = r_content_left - LEN_W'(1);
                    if (last_byte) begin
                        // record content done: padding if any, else next header
                        n_content_left = '0;
                        n_phase = (r_pad_left != '0) ? PH_PADDING : PH_HEADER;
                    end
                end
                PH_PADDING: begin
                    n_pad_left = r_pad_left - PAD_W'(1);
                    if (n_pad_left == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    // header byte; an unused phase code is taken as header too
                    n_phase = PH_HEADER;
                    case (r_hidx)
                        HDR_TYPE:   n_rec_type = i_in.in_byte;
                        HDR_REQ_HI: n_req = {i_in.in_byte, r_req[7:0]};
                        HDR_REQ_LO: n_req = {r_req[15:8], i_in.in_byte};
                        HDR_LEN_HI: n_content_left = {i_in.in_byte, r_content_left[7:0]};
                        HDR_LEN_LO: n_content_left = {r_content_left[15:8], i_in.in_byte};
                        HDR_PAD:    n_pad_left = i_in.in_byte;
                        default:    ;
                    endcase
                    if (r_hidx == HDR_LAST) begin
                        n_hidx = '0;
                        if (r_content_left != '0) begin
                            n_phase = PH_CONTENT;
                        end else if (r_pad_left != '0) begin
                            n_phase = PH_PADDING;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_hidx = r_hidx + HIDX_W'(1);
                    end
                end
            endcase
        end
    end

    // Outputs: a result word for each content byte of a tagged record.
    always_comb begin
        res_valid            = in_accept && (r_phase == PH_CONTENT) && kind_ok;
        res_data.data_byte   = i_in.in_byte;
        res_data.stream_kind = kind;
        res_data.request_id  = r_req;
        res_data.record_last = last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_hidx         <= '0;
            r_rec_type     <= '0;
            r_req          <= '0;
            r_content_left <= '0;
            r_pad_left     <= '0;
        end else begin
            r_phase        <= n_phase;
            r_hidx         <= n_hidx;
            r_rec_type     <= n_rec_type;
            r_req          <= n_req;
            r_content_left <= n_content_left;
            r_pad_left     <= n_pad_left;
        end
    end

    // Result register with skid entry; holds words while o_out stalls.
    fcgi_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (buf_ready),
        .i_data  (res_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_data)
    );

    assign o_out.data_byte   = out_data.data_byte;
    assign o_out.stream_kind = out_data.stream_kind;
    assign o_out.request_id  = out_data.request_id;
    assign o_out.record_last = out_data.record_last;

    a_hidx_only_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hidx != '0) |-> (r_phase == PH_HEADER))
        else $error("header index left nonzero outside header phase");

    a_content_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONTENT) |-> (r_content_left != '0))
        else $error("content phase with no content left");

    a_padding_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PADDING) |-> (r_pad_left != '0))
        else $error("padding phase with no padding left");

    a_last_ends_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && last_byte) |=> (r_phase != PH_CONTENT))
        else $error("content phase kept after last content byte");

endmodule
